// ===== hdl/bsia_pkg.sv =====
package bsia_pkg;

    localparam int OP_W      = 3;
    localparam int POS_W     = 4;
    localparam int IO_WORD_W = 32;
    localparam int ST_W      = 2;
    localparam int CNT_W     = 4;
    localparam int CAP_W     = 4;

    localparam int                 DEF_DEPTH      = 8;
    localparam int                 DEF_WORD_WIDTH = 32;
    localparam logic [CAP_W-1:0]   CAP_RESET      = CAP_W'(5);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_PEEK   = 3'd2,
        OP_CHANGE = 3'd3,
        OP_CLEAR  = 3'd4
    } t_op;

    typedef enum logic [ST_W-1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2,
        STS_RANGE = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_HOLD = 1'b1
    } t_state;

    typedef struct packed {
        logic             load;
        logic             wr_en;
        logic             wr_top;
        logic             peek_ok;
        logic [CNT_W-1:0] nxt_count;
        t_status          status;
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] cap_eff;
    } t_dp_stat;

endpackage

// ===== hdl/bsia_in_if.sv =====
interface bsia_in_if
    import bsia_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      op;
    logic [POS_W-1:0]     position;
    logic [IO_WORD_W-1:0] write_word;

    modport source (output valid, output op, output position, output write_word, input ready);
    modport sink   (input valid, input op, input position, input write_word, output ready);
endinterface

// ===== hdl/bsia_out_if.sv =====
interface bsia_out_if
    import bsia_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [ST_W-1:0]      status;
    logic [IO_WORD_W-1:0] read_word;
    logic [CNT_W-1:0]     count;
    logic                 is_full;
    logic                 is_empty;

    modport source (output valid, output status, output read_word, output count,
                    output is_full, output is_empty, input ready);
    modport sink   (input valid, input status, input read_word, input count,
                    input is_full, input is_empty, output ready);
endinterface

// ===== hdl/bsia_ctrl.sv =====
module bsia_ctrl
    import bsia_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [OP_W-1:0]  i_op,
    input  logic [POS_W-1:0] i_position,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  t_dp_stat         i_stat,
    output t_cmd             o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   pos_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign pos_bad = (i_position == '0) || (i_position > i_stat.count);

    always_comb begin
        n_state     = r_state;
        o_out_valid = 1'b0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_HOLD: begin
                o_out_valid = 1'b1;
                o_in_ready  = i_out_ready;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase

        o_cmd           = '0;
        o_cmd.load      = i_in_valid && o_in_ready;
        o_cmd.nxt_count = i_stat.count;
        o_cmd.status    = STS_OK;

        // op decode
        unique case (t_op'(i_op))
            OP_PUSH: begin
                if (i_stat.count >= i_stat.cap_eff) begin
                    o_cmd.status = STS_FULL;
                end else begin
                    o_cmd.wr_en     = 1'b1;
                    o_cmd.wr_top    = 1'b1;
                    o_cmd.nxt_count = i_stat.count + CNT_W'(1);
                end
            end
            OP_POP: begin
                if (i_stat.count == '0) begin
                    o_cmd.status = STS_EMPTY;
                end else begin
                    o_cmd.nxt_count = i_stat.count - CNT_W'(1);
                end
            end
            OP_PEEK: begin
                if (i_stat.count == '0) begin
                    o_cmd.status = STS_EMPTY;
                end else if (pos_bad) begin
                    o_cmd.status = STS_RANGE;
                end else begin
                    o_cmd.peek_ok = 1'b1;
                end
            end
            OP_CHANGE: begin
                if (pos_bad) begin
                    o_cmd.status = STS_RANGE;
                end else begin
                    o_cmd.wr_en = 1'b1;
                end
            end
            OP_CLEAR: begin
                o_cmd.nxt_count = '0;
            end
            default: begin
                o_cmd.status = STS_OK;
            end
        endcase

        if (!o_cmd.load) begin
            o_cmd.wr_en = 1'b0;
        end

        if (o_cmd.load) begin
            n_state = S_HOLD;
        end else if (r_state == S_HOLD && i_out_ready) begin
            n_state = S_IDLE;
        end
    end

endmodule

// ===== hdl/bsia_dp.sv =====
module bsia_dp
    import bsia_pkg::*;
#(
    parameter int DEPTH      = DEF_DEPTH,
    parameter int WORD_WIDTH = DEF_WORD_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CAP_W-1:0]     i_cfg_data,
    input  logic [POS_W-1:0]     i_position,
    input  logic [IO_WORD_W-1:0] i_write_word,
    input  t_cmd                 i_cmd,
    output t_dp_stat             o_stat,
    output logic [ST_W-1:0]      o_status,
    output logic [IO_WORD_W-1:0] o_read_word,
    output logic [CNT_W-1:0]     o_count,
    output logic                 o_is_full,
    output logic                 o_is_empty
);

    localparam int               AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int               CapMax  = (DEPTH < 15) ? DEPTH : 15;
    localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(CapMax);

    logic [WORD_WIDTH-1:0] mem [DEPTH];
    logic [WORD_WIDTH-1:0] r_rdata;
    logic [CAP_W-1:0]      r_cap;
    logic [CNT_W-1:0]      r_top;
    logic [ST_W-1:0]       r_status;
    logic [CNT_W-1:0]      r_count;
    logic                  r_full;
    logic                  r_empty;
    logic                  r_peek_ok;
    logic [CNT_W-1:0]      cap_eff;
    logic [CNT_W-1:0]      depth_off;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;

    always_comb begin
        if (r_cap == '0) begin
            cap_eff = CNT_W'(1);
        end else if (r_cap > CAP_MAX) begin
            cap_eff = CAP_MAX;
        end else begin
            cap_eff = r_cap;
        end
    end

    assign depth_off = r_top - i_position;
    assign rd_addr   = AW'(depth_off);
    assign wr_addr   = i_cmd.wr_top ? AW'(r_top) : rd_addr;

    assign o_stat.count   = r_top;
    assign o_stat.cap_eff = cap_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
            r_top <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_top <= i_cmd.nxt_count;
            end
        end
    end

    // entry storage, one write and one read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[wr_addr] <= WORD_WIDTH'(i_write_word);
        end
        if (i_cmd.load) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_status  <= i_cmd.status;
            r_count   <= i_cmd.nxt_count;
            r_full    <= (i_cmd.nxt_count >= cap_eff);
            r_empty   <= (i_cmd.nxt_count == '0);
            r_peek_ok <= i_cmd.peek_ok;
        end
    end

    assign o_status    = r_status;
    assign o_count     = r_count;
    assign o_is_full   = r_full;
    assign o_is_empty  = r_empty;
    assign o_read_word = r_peek_ok ? IO_WORD_W'(r_rdata) : '0;

endmodule

// ===== hdl/bounded_stack_with_indexed_access.sv =====
// bounded lifo stack with read and overwrite by depth from the top
// input channel i_in carries op, position and write_word; every accepted word
// yields exactly one result word on o_out: status, read_word, count and the
// is_full / is_empty flags taken after the operation
// result: registered, loaded by the clock edge that accepts the input word
// throughput: one word per cycle while o_out.ready stays high; the entry
// store has one write and one registered read port, both used in the accept
// cycle, and the result register is loaded in that same cycle
// stall: while o_out.ready is low the result holds and i_in.ready is low; a
// new word is taken in the same cycle the waiting result is taken
// config: i_cfg_we writes capacity from i_cfg_data; capacity zero acts as one
// and values above the depth act as the depth
// reset (synchronous, active low): stack emptied, capacity back to 5, no
// result pending; entry contents are not cleared and need no clearing pass
module bounded_stack_with_indexed_access
    import bsia_pkg::*;
#(
    parameter int DEPTH      = DEF_DEPTH,
    parameter int WORD_WIDTH = DEF_WORD_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_data,
    bsia_in_if.sink          i_in,
    bsia_out_if.source       o_out
);

    t_cmd     cmd;
    t_dp_stat stat;

    bsia_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_op        (i_in.op),
        .i_position  (i_in.position),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    bsia_dp #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_position   (i_in.position),
        .i_write_word (i_in.write_word),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_status     (o_out.status),
        .o_read_word  (o_out.read_word),
        .o_count      (o_out.count),
        .o_is_full    (o_out.is_full),
        .o_is_empty   (o_out.is_empty)
    );

endmodule

// ===== hdl/bsia_chk.sv =====
module bsia_chk
    import bsia_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic [ST_W-1:0]      i_status,
    input logic [IO_WORD_W-1:0] i_read_word,
    input logic [CNT_W-1:0]     i_count,
    input logic                 i_is_full,
    input logic                 i_is_empty
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_read_word) && $stable(i_count))
        else $error("result changed while stalled");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_is_empty == (i_count == '0)))
        else $error("empty flag disagrees with count");

    a_not_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_is_full && i_is_empty))
        else $error("full and empty together");

    a_refused_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == STS_FULL) |-> i_is_full && (i_read_word == '0))
        else $error("refused push without full flag");

    a_refused_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == STS_EMPTY) |-> i_is_empty && (i_read_word == '0))
        else $error("refused on empty without empty flag");

endmodule

bind bounded_stack_with_indexed_access bsia_chk u_bsia_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_status    (o_out.status),
    .i_read_word (o_out.read_word),
    .i_count     (o_out.count),
    .i_is_full   (o_out.is_full),
    .i_is_empty  (o_out.is_empty)
);
